// ===== rtl/spds_pkg.sv =====
// Shared types, constants and helper functions for the sprite pixel scaler.
// Used by every module of the block; depends on nothing else.

package spds_pkg;

	// Default sizes of the block.
	localparam int RAYS_DEF         = 1024;
	localparam int SCREEN_WIDTH_DEF = 1920;
	localparam int TEX_SIZE_DEF     = 64;

	// Fixed field widths.
	localparam int COORD_W = 12;
	localparam int BOX_W   = 13;
	localparam int DIFF_W  = 13;
	localparam int DEPTH_W = 24;
	localparam int COLOR_W = 32;
	localparam int SLOT_W  = 10;
	localparam int TEXI_W  = 6;
	localparam int RAY_W   = 24;
	localparam int CFG_W   = 32;
	localparam int IN_W    = 104;
	localparam int OUT_W   = 40;

	// Request kinds.
	typedef enum logic [1:0] {
		REQ_LOAD_DEPTH = 2'd0,
		REQ_LOAD_TEXEL = 2'd1,
		REQ_QUERY      = 2'd2
	} req_t;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		CFG_LEFT   = 3'd0,
		CFG_RIGHT  = 3'd1,
		CFG_TOP    = 3'd2,
		CFG_BOTTOM = 3'd3,
		CFG_DEPTH  = 3'd4,
		CFG_WIN_W  = 3'd5,
		CFG_WIN_H  = 3'd6,
		CFG_TINT   = 3'd7
	} cfg_idx_t;

	// Per-request data that follows a request down the pipeline.
	typedef struct packed {
		req_t                req;
		logic                ok;
		logic [RAY_W-1:0]    ray;
		logic [SLOT_W-1:0]   slot;
		logic [DEPTH_W-1:0]  dval;
		logic [TEXI_W-1:0]   tc;
		logic [TEXI_W-1:0]   tr;
		logic [COLOR_W-1:0]  tval;
	} sb_t;

	// Number of quotient bits needed for a texture index.
	function automatic int qbits(input int tex_size);
		int r;
		r = (tex_size > 1) ? $clog2(tex_size) : 1;
		return r;
	endfunction

	// Per-byte average of two ARGB words, rounded down.
	function automatic logic [COLOR_W-1:0] blend_avg(input logic [COLOR_W-1:0] a,
			input logic [COLOR_W-1:0] b);
		logic [8:0] s3, s2, s1, s0;
		s3 = {1'b0, a[31:24]} + {1'b0, b[31:24]};
		s2 = {1'b0, a[23:16]} + {1'b0, b[23:16]};
		s1 = {1'b0, a[15:8]}  + {1'b0, b[15:8]};
		s0 = {1'b0, a[7:0]}   + {1'b0, b[7:0]};
		return {s3[8:1], s2[8:1], s1[8:1], s0[8:1]};
	endfunction

endpackage

// ===== rtl/spds_div.sv =====
// Pipelined restoring divider that turns box offsets into texture indexes.
// One quotient bit per stage for the column and row lanes; uses spds_pkg.

module spds_div #(
	parameter int TEX_SIZE = spds_pkg::TEX_SIZE_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_valid,
	input  spds_pkg::sb_t                         in_sb,
	input  logic [spds_pkg::DIFF_W-1:0]           dx,
	input  logic [spds_pkg::DIFF_W-1:0]           dy,
	input  logic [spds_pkg::DIFF_W-1:0]           w,
	input  logic [spds_pkg::DIFF_W-1:0]           h,
	output logic                                  out_valid,
	output spds_pkg::sb_t                         out_sb,
	output logic [spds_pkg::qbits(TEX_SIZE)-1:0]  qc,
	output logic [spds_pkg::qbits(TEX_SIZE)-1:0]  qr
);

	localparam int QB  = spds_pkg::qbits(TEX_SIZE);
	localparam int NDW = spds_pkg::DIFF_W + $clog2(TEX_SIZE + 1);
	localparam int RW  = NDW + QB;

	logic                        v_q  [QB];
	spds_pkg::sb_t               sb_q [QB];
	logic [RW-1:0]               rc_q [QB];
	logic [RW-1:0]               rr_q [QB];
	logic [spds_pkg::DIFF_W-1:0] w_q  [QB];
	logic [spds_pkg::DIFF_W-1:0] h_q  [QB];
	logic [QB-1:0]               qc_q [QB];
	logic [QB-1:0]               qr_q [QB];

	for (genvar j = 0; j < QB; j++) begin : g_stage
		localparam int B = QB - 1 - j;
		logic                        in_v;
		spds_pkg::sb_t               in_s;
		logic [RW-1:0]               in_rc;
		logic [RW-1:0]               in_rr;
		logic [spds_pkg::DIFF_W-1:0] in_w;
		logic [spds_pkg::DIFF_W-1:0] in_h;
		logic [QB-1:0]               in_qc;
		logic [QB-1:0]               in_qr;
		logic [RW-1:0]               dc;
		logic [RW-1:0]               dr;
		logic                        gec;
		logic                        ger;

		// The first stage scales the offsets by the texture size.
		if (j == 0) begin : g_first
			assign in_v  = in_valid;
			assign in_s  = in_sb;
			assign in_rc = RW'(dx) * RW'(TEX_SIZE);
			assign in_rr = RW'(dy) * RW'(TEX_SIZE);
			assign in_w  = w;
			assign in_h  = h;
			assign in_qc = '0;
			assign in_qr = '0;
		end else begin : g_next
			assign in_v  = v_q[j-1];
			assign in_s  = sb_q[j-1];
			assign in_rc = rc_q[j-1];
			assign in_rr = rr_q[j-1];
			assign in_w  = w_q[j-1];
			assign in_h  = h_q[j-1];
			assign in_qc = qc_q[j-1];
			assign in_qr = qr_q[j-1];
		end

		// Trial subtract of the shifted divisor decides this quotient bit.
		assign dc  = RW'(in_w) << B;
		assign dr  = RW'(in_h) << B;
		assign gec = (in_rc >= dc);
		assign ger = (in_rr >= dr);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[j] <= 1'b0;
			end else if (en) begin
				v_q[j] <= in_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sb_q[j] <= in_s;
				rc_q[j] <= gec ? (in_rc - dc) : in_rc;
				rr_q[j] <= ger ? (in_rr - dr) : in_rr;
				w_q[j]  <= in_w;
				h_q[j]  <= in_h;
				qc_q[j] <= in_qc | (QB'(gec) << B);
				qr_q[j] <= in_qr | (QB'(ger) << B);
			end
		end
	end

	assign out_valid = v_q[QB-1];
	assign out_sb    = sb_q[QB-1];
	assign qc        = qc_q[QB-1];
	assign qr        = qr_q[QB-1];

endmodule

// ===== rtl/spds_depth.sv =====
// Per-ray depth memory stage: writes depth loads and reads the query's ray.
// Synchronous memory with a registered read; uses spds_pkg.

module spds_depth #(
	parameter int RAYS     = spds_pkg::RAYS_DEF,
	parameter int TEX_SIZE = spds_pkg::TEX_SIZE_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_valid,
	input  spds_pkg::sb_t                         in_sb,
	input  logic [spds_pkg::qbits(TEX_SIZE)-1:0]  in_qc,
	input  logic [spds_pkg::qbits(TEX_SIZE)-1:0]  in_qr,
	output logic                                  out_valid,
	output spds_pkg::sb_t                         out_sb,
	output logic [spds_pkg::qbits(TEX_SIZE)-1:0]  out_qc,
	output logic [spds_pkg::qbits(TEX_SIZE)-1:0]  out_qr,
	output logic                                  out_ray_ok,
	output logic [spds_pkg::DEPTH_W-1:0]          out_depth
);

	localparam int QB = spds_pkg::qbits(TEX_SIZE);
	localparam int AW = $clog2(RAYS);

	logic [spds_pkg::DEPTH_W-1:0] mem [RAYS];
	logic [12:0]                  slot_ext;
	logic                         wr;
	logic                         v_q;
	spds_pkg::sb_t                sb_q;
	logic [QB-1:0]                qc_q;
	logic [QB-1:0]                qr_q;
	logic                         ray_ok_q;
	logic [spds_pkg::DEPTH_W-1:0] rd_q;

	// Depth loads outside the store are dropped.
	assign slot_ext = 13'(in_sb.slot);
	assign wr = in_valid && (in_sb.req == spds_pkg::REQ_LOAD_DEPTH)
		&& (slot_ext < 13'(RAYS));

	// Memory port: write and read happen at the same stage, so order holds.
	always_ff @(posedge clk) begin
		if (en) begin
			if (wr) begin
				mem[slot_ext[AW-1:0]] <= in_sb.dval;
			end
			rd_q <= mem[in_sb.ray[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_q     <= in_sb;
			qc_q     <= in_qc;
			qr_q     <= in_qr;
			ray_ok_q <= (in_sb.ray < spds_pkg::RAY_W'(RAYS));
		end
	end

	assign out_valid  = v_q;
	assign out_sb     = sb_q;
	assign out_qc     = qc_q;
	assign out_qr     = qr_q;
	assign out_ray_ok = ray_ok_q;
	assign out_depth  = rd_q;

endmodule

// ===== rtl/spds_tex.sv =====
// Depth compare and texture memory stage: writes texel loads, reads texels.
// Synchronous memory with a registered read; uses spds_pkg.

module spds_tex #(
	parameter int TEX_SIZE = spds_pkg::TEX_SIZE_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  in_valid,
	input  spds_pkg::sb_t                         in_sb,
	input  logic [spds_pkg::qbits(TEX_SIZE)-1:0]  in_qc,
	input  logic [spds_pkg::qbits(TEX_SIZE)-1:0]  in_qr,
	input  logic                                  in_ray_ok,
	input  logic [spds_pkg::DEPTH_W-1:0]          in_depth,
	input  logic [spds_pkg::DEPTH_W-1:0]          sprite_depth,
	output logic                                  out_valid,
	output logic                                  out_draw,
	output logic [spds_pkg::COLOR_W-1:0]          out_texel
);

	localparam int QB    = spds_pkg::qbits(TEX_SIZE);
	localparam int AW    = (TEX_SIZE > 1) ? $clog2(TEX_SIZE * TEX_SIZE) : 1;
	localparam int DEPTH = TEX_SIZE * TEX_SIZE;
	localparam logic [QB-1:0] TMAX = QB'(TEX_SIZE - 1);

	logic [spds_pkg::COLOR_W-1:0] mem [DEPTH];
	logic [QB-1:0]                ci;
	logic [QB-1:0]                ri;
	logic [16:0]                  rd_addr;
	logic [16:0]                  wr_addr;
	logic                         wr;
	logic                         hide;
	logic                         v_q;
	logic                         draw_q;
	logic [spds_pkg::COLOR_W-1:0] rd_q;

	// Clamp the scaled indexes into the texture.
	assign ci = ((QB+1)'(in_qc) >= (QB+1)'(TEX_SIZE)) ? TMAX : in_qc;
	assign ri = ((QB+1)'(in_qr) >= (QB+1)'(TEX_SIZE)) ? TMAX : in_qr;
	assign rd_addr = 17'(ci) * 17'(TEX_SIZE) + 17'(ri);
	assign wr_addr = 17'(in_sb.tc) * 17'(TEX_SIZE) + 17'(in_sb.tr);

	// Texel loads outside the texture are dropped.
	assign wr = in_valid && (in_sb.req == spds_pkg::REQ_LOAD_TEXEL)
		&& (9'(in_sb.tc) < 9'(TEX_SIZE)) && (9'(in_sb.tr) < 9'(TEX_SIZE));

	// A nearer wall hides the sprite; a tie does not.
	assign hide = in_ray_ok && (in_depth < sprite_depth);

	always_ff @(posedge clk) begin
		if (en) begin
			if (wr) begin
				mem[wr_addr[AW-1:0]] <= in_sb.tval;
			end
			rd_q   <= mem[rd_addr[AW-1:0]];
			draw_q <= (in_sb.req == spds_pkg::REQ_QUERY) && in_sb.ok && !hide;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_valid;
		end
	end

	assign out_valid = v_q;
	assign out_draw  = draw_q;
	assign out_texel = rd_q;

endmodule

// ===== rtl/sprite_pixel_scaler_depth_test_core.sv =====
// Sprite pixel scaler with depth test, top level.
// A request passes the stage 1 and stage 2 registers, the one-bit-per-stage
// texture index divider, the depth and texture stages and the output register.
// Throughput: one request per cycle; a held result stalls the whole pipeline.
// Reset clears the pipeline and sets the registers to their defaults; the
// depth and texture memories are undefined until written.

module sprite_pixel_scaler_depth_test_core #(
	parameter int RAYS         = spds_pkg::RAYS_DEF,
	parameter int SCREEN_WIDTH = spds_pkg::SCREEN_WIDTH_DEF,
	parameter int TEX_SIZE     = spds_pkg::TEX_SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [2:0]                    wr_index,
	input  logic [spds_pkg::CFG_W-1:0]    wr_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// req_type[1:0], pos_x[13:2], pos_y[25:14], ray_slot[35:26],
	// depth_value[59:36], tex_col[65:60], tex_row[71:66], texel_value[103:72]
	input  logic [spds_pkg::IN_W-1:0]     s_tdata,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// draw_pixel[0], pixel_color[32:1], zero fill[39:33]
	output logic [spds_pkg::OUT_W-1:0]    m_tdata
);

	localparam int QB        = spds_pkg::qbits(TEX_SIZE);
	localparam int RS        = spds_pkg::RAY_W + $clog2(SCREEN_WIDTH);
	localparam longint RECIP = ((64'd1 << RS) + SCREEN_WIDTH - 1) / SCREEN_WIDTH;
	localparam int RECIP_W   = $clog2(RECIP + 1);
	localparam int PROD_W    = spds_pkg::RAY_W + RECIP_W;

	// Configuration registers.
	logic signed [spds_pkg::BOX_W-1:0] left_q, right_q, top_q, bottom_q;
	logic [spds_pkg::DEPTH_W-1:0]      depth_q;
	logic [spds_pkg::BOX_W-1:0]        win_w_q, win_h_q;
	logic [spds_pkg::COLOR_W-1:0]      tint_q;

	logic en;

	// Stage 1: unpacked request.
	logic                           v_s1;
	logic [1:0]                     req_s1;
	logic [spds_pkg::COORD_W-1:0]   px_s1, py_s1;
	logic [spds_pkg::SLOT_W-1:0]    slot_s1;
	logic [spds_pkg::DEPTH_W-1:0]   dval_s1;
	logic [spds_pkg::TEXI_W-1:0]    tc_s1, tr_s1;
	logic [spds_pkg::COLOR_W-1:0]   tval_s1;
	logic                           box_ok;
	logic signed [13:0]             dx_full, dy_full, w_full, h_full;
	logic [spds_pkg::RAY_W-1:0]     n_c;

	// Stage 2: box test done, ray product pending.
	logic                           v_s2;
	spds_pkg::sb_t                  sb_s2;
	logic [spds_pkg::RAY_W-1:0]     n_s2;
	logic [spds_pkg::DIFF_W-1:0]    dx_s2, dy_s2, w_s2, h_s2;
	logic [PROD_W-1:0]              prod;
	spds_pkg::sb_t                  sb_div;

	// Later stages.
	logic                           div_v;
	spds_pkg::sb_t                  div_sb;
	logic [QB-1:0]                  div_qc, div_qr;
	logic                           dep_v;
	spds_pkg::sb_t                  dep_sb;
	logic [QB-1:0]                  dep_qc, dep_qr;
	logic                           dep_ray_ok;
	logic [spds_pkg::DEPTH_W-1:0]   dep_depth;
	logic                           tex_v;
	logic                           tex_draw;
	logic [spds_pkg::COLOR_W-1:0]   tex_texel;
	logic [spds_pkg::COLOR_W-1:0]   color_c;

	// Output register.
	logic                           out_v_q;
	logic                           draw_q;
	logic [spds_pkg::COLOR_W-1:0]   color_q;

	// True when c lies in [max(lo, 0), hi) and below lim.
	function automatic logic in_span(input logic [spds_pkg::COORD_W-1:0] c,
			input logic signed [spds_pkg::BOX_W-1:0] lo,
			input logic signed [spds_pkg::BOX_W-1:0] hi,
			input logic [spds_pkg::BOX_W-1:0] lim);
		logic signed [14:0] cs, los, his, lims, start;
		cs    = $signed({3'b000, c});
		los   = $signed({{2{lo[12]}}, lo});
		his   = $signed({{2{hi[12]}}, hi});
		lims  = $signed({2'b00, lim});
		start = (los > 15'sd0) ? los : 15'sd0;
		return (cs >= start) && (cs < his) && (cs < lims);
	endfunction

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			right_q  <= '0;
			top_q    <= '0;
			bottom_q <= '0;
			depth_q  <= '0;
			win_w_q  <= 13'd1920;
			win_h_q  <= 13'd1080;
			tint_q   <= '0;
		end else if (wr_en) begin
			case (spds_pkg::cfg_idx_t'(wr_index))
				spds_pkg::CFG_LEFT:   left_q   <= wr_data[12:0];
				spds_pkg::CFG_RIGHT:  right_q  <= wr_data[12:0];
				spds_pkg::CFG_TOP:    top_q    <= wr_data[12:0];
				spds_pkg::CFG_BOTTOM: bottom_q <= wr_data[12:0];
				spds_pkg::CFG_DEPTH:  depth_q  <= wr_data[23:0];
				spds_pkg::CFG_WIN_W:  win_w_q  <= wr_data[12:0];
				spds_pkg::CFG_WIN_H:  win_h_q  <= wr_data[12:0];
				spds_pkg::CFG_TINT:   tint_q   <= wr_data;
				default: ;
			endcase
		end
	end

	// The whole pipeline moves unless a result waits at the output.
	assign en       = !out_v_q || m_tready;
	assign s_tready = en;

	// Stage 1 register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			req_s1  <= s_tdata[1:0];
			px_s1   <= s_tdata[13:2];
			py_s1   <= s_tdata[25:14];
			slot_s1 <= s_tdata[35:26];
			dval_s1 <= s_tdata[59:36];
			tc_s1   <= s_tdata[65:60];
			tr_s1   <= s_tdata[71:66];
			tval_s1 <= s_tdata[103:72];
		end
	end

	// Box test, offsets into the box and the unscaled ray product.
	assign box_ok  = in_span(px_s1, left_q, right_q, win_w_q)
		&& in_span(py_s1, top_q, bottom_q, win_h_q);
	assign dx_full = $signed({2'b00, px_s1}) - $signed({left_q[12], left_q});
	assign dy_full = $signed({2'b00, py_s1}) - $signed({top_q[12], top_q});
	assign w_full  = $signed({right_q[12], right_q}) - $signed({left_q[12], left_q});
	assign h_full  = $signed({bottom_q[12], bottom_q}) - $signed({top_q[12], top_q});
	assign n_c     = spds_pkg::RAY_W'(px_s1) * spds_pkg::RAY_W'(RAYS);

	// Stage 2 register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s2.req  <= spds_pkg::req_t'(req_s1);
			sb_s2.ok   <= box_ok;
			sb_s2.ray  <= '0;
			sb_s2.slot <= slot_s1;
			sb_s2.dval <= dval_s1;
			sb_s2.tc   <= tc_s1;
			sb_s2.tr   <= tr_s1;
			sb_s2.tval <= tval_s1;
			n_s2       <= n_c;
			dx_s2      <= dx_full[12:0];
			dy_s2      <= dy_full[12:0];
			w_s2       <= w_full[12:0];
			h_s2       <= h_full[12:0];
		end
	end

	// Ray slot by reciprocal multiply; exact for every product value.
	assign prod = PROD_W'(n_s2) * PROD_W'(RECIP);
	always_comb begin
		sb_div     = sb_s2;
		sb_div.ray = spds_pkg::RAY_W'(prod >> RS);
	end

	spds_div #(
		.TEX_SIZE (TEX_SIZE)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.in_sb     (sb_div),
		.dx        (dx_s2),
		.dy        (dy_s2),
		.w         (w_s2),
		.h         (h_s2),
		.out_valid (div_v),
		.out_sb    (div_sb),
		.qc        (div_qc),
		.qr        (div_qr)
	);

	spds_depth #(
		.RAYS     (RAYS),
		.TEX_SIZE (TEX_SIZE)
	) u_depth (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (div_v),
		.in_sb      (div_sb),
		.in_qc      (div_qc),
		.in_qr      (div_qr),
		.out_valid  (dep_v),
		.out_sb     (dep_sb),
		.out_qc     (dep_qc),
		.out_qr     (dep_qr),
		.out_ray_ok (dep_ray_ok),
		.out_depth  (dep_depth)
	);

	spds_tex #(
		.TEX_SIZE (TEX_SIZE)
	) u_tex (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.in_valid     (dep_v),
		.in_sb        (dep_sb),
		.in_qc        (dep_qc),
		.in_qr        (dep_qr),
		.in_ray_ok    (dep_ray_ok),
		.in_depth     (dep_depth),
		.sprite_depth (depth_q),
		.out_valid    (tex_v),
		.out_draw     (tex_draw),
		.out_texel    (tex_texel)
	);

	// Tint: a zero tint keeps texels; else average opaque ones with it, clear others.
	always_comb begin
		if (!tex_draw) begin
			color_c = '0;
		end else if (tint_q == '0) begin
			color_c = tex_texel;
		end else if (tex_texel[31:24] != 8'd0) begin
			color_c = spds_pkg::blend_avg(tex_texel, tint_q);
		end else begin
			color_c = '0;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en) begin
			out_v_q <= tex_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			draw_q  <= tex_draw;
			color_q <= color_c;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {7'b0000000, color_q, draw_q};

	// A waiting result must hold back new requests.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !m_tready |-> !s_tready)
		else $error("request taken while a result was held");

	// A pixel that is not drawn carries no color.
	a_undrawn_black: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[32:1] == 32'd0)
		else $error("color present on a pixel that is not drawn");

	// A result left in place by a stall is not replaced.
	a_held_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !m_tready |=> out_v_q && $stable(color_q) && $stable(draw_q))
		else $error("held result changed");

endmodule
